FILE: hdl/cwk_pkg.sv
// cwk_pkg: shared types, codes and the morse code table for the cw keyer
// no dependencies; used by every module of the keyer but cwk_sine_rom
`timescale 1ns / 1ps

package cwk_pkg;

    // input command codes
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_DIT_SAMPLES  = 2'd0;
    localparam logic [1:0] REG_RAMP_SAMPLES = 2'd1;
    localparam logic [1:0] REG_RAMP_GAIN    = 2'd2;
    localparam logic [1:0] REG_PHASE_STEP   = 2'd3;

    localparam int unsigned COUNT_W = 20;
    localparam int unsigned ENV_W   = 17;
    localparam int unsigned MAG_W   = 15;

    // unity envelope in q1.15
    localparam logic [ENV_W-1:0] ENV_ONE = 17'd32768;

    typedef enum logic [4:0] {
        KIND_IDLE       = 5'b00001,
        KIND_TONE       = 5'b00010,
        KIND_ELEM_GAP   = 5'b00100,
        KIND_LETTER_GAP = 5'b01000,
        KIND_WORD_GAP   = 5'b10000
    } seg_kind_t;

    // per item control that travels down the sample pipeline
    typedef struct packed {
        logic accepted;
        logic busy_res;
        logic is_tone;
        logic env_full;
    } cwk_flags_t;

    // element count and pattern, bit i set means element i is a dah
    typedef struct packed {
        logic [2:0] count;
        logic [6:0] pattern;
    } morse_code_t;

    // indexed by ascii code minus 32
    function automatic morse_code_t morse_lookup(input logic [5:0] idx);
        morse_code_t c;
        c = '{count: 3'd0, pattern: 7'd0};
        unique case (idx)
            6'd1:  c = '{3'd6, 7'b0110101}; // !
            6'd2:  c = '{3'd6, 7'b0010010}; // "
            6'd4:  c = '{3'd7, 7'b1001000}; // $
            6'd6:  c = '{3'd5, 7'b0000010}; // &
            6'd7:  c = '{3'd6, 7'b0011110}; // '
            6'd8:  c = '{3'd5, 7'b0001101}; // (
            6'd9:  c = '{3'd6, 7'b0101101}; // )
            6'd11: c = '{3'd5, 7'b0001010}; // +
            6'd12: c = '{3'd6, 7'b0110011}; // ,
            6'd13: c = '{3'd6, 7'b0100001}; // -
            6'd14: c = '{3'd6, 7'b0101010}; // .
            6'd15: c = '{3'd5, 7'b0001001}; // /
            6'd16: c = '{3'd5, 7'b0011111}; // 0
            6'd17: c = '{3'd5, 7'b0011110}; // 1
            6'd18: c = '{3'd5, 7'b0011100}; // 2
            6'd19: c = '{3'd5, 7'b0011000}; // 3
            6'd20: c = '{3'd5, 7'b0010000}; // 4
            6'd21: c = '{3'd5, 7'b0000000}; // 5
            6'd22: c = '{3'd5, 7'b0000001}; // 6
            6'd23: c = '{3'd5, 7'b0000011}; // 7
            6'd24: c = '{3'd5, 7'b0000111}; // 8
            6'd25: c = '{3'd5, 7'b0001111}; // 9
            6'd26: c = '{3'd6, 7'b0000111}; // :
            6'd27: c = '{3'd6, 7'b0010101}; // ;
            6'd29: c = '{3'd5, 7'b0010001}; // =
            6'd31: c = '{3'd6, 7'b0001100}; // ?
            6'd32: c = '{3'd6, 7'b0010110}; // @
            6'd33: c = '{3'd2, 7'b0000010}; // A
            6'd34: c = '{3'd4, 7'b0000001}; // B
            6'd35: c = '{3'd4, 7'b0000101}; // C
            6'd36: c = '{3'd3, 7'b0000001}; // D
            6'd37: c = '{3'd1, 7'b0000000}; // E
            6'd38: c = '{3'd4, 7'b0000100}; // F
            6'd39: c = '{3'd3, 7'b0000011}; // G
            6'd40: c = '{3'd4, 7'b0000000}; // H
            6'd41: c = '{3'd2, 7'b0000000}; // I
            6'd42: c = '{3'd4, 7'b0001110}; // J
            6'd43: c = '{3'd3, 7'b0000101}; // K
            6'd44: c = '{3'd4, 7'b0000010}; // L
            6'd45: c = '{3'd2, 7'b0000011}; // M
            6'd46: c = '{3'd2, 7'b0000001}; // N
            6'd47: c = '{3'd3, 7'b0000111}; // O
            6'd48: c = '{3'd4, 7'b0000110}; // P
            6'd49: c = '{3'd4, 7'b0001011}; // Q
            6'd50: c = '{3'd3, 7'b0000010}; // R
            6'd51: c = '{3'd3, 7'b0000000}; // S
            6'd52: c = '{3'd1, 7'b0000001}; // T
            6'd53: c = '{3'd3, 7'b0000100}; // U
            6'd54: c = '{3'd4, 7'b0001000}; // V
            6'd55: c = '{3'd3, 7'b0000110}; // W
            6'd56: c = '{3'd4, 7'b0001001}; // X
            6'd57: c = '{3'd4, 7'b0001101}; // Y
            6'd58: c = '{3'd4, 7'b0000011}; // Z
            6'd63: c = '{3'd6, 7'b0101100}; // _
            default: c = '{count: 3'd0, pattern: 7'd0};
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/morse_cw_keyer_core.sv
// morse_cw_keyer_core: top level, configuration registers and stream handshake
// depends on cwk_pkg, cwk_seq, cwk_shaper (and cwk_sine_rom below it)
`timescale 1ns / 1ps

// Morse keyer with ramped sine tone. Each input transfer is either a character
// submit (s_tuser 0) or a sample tick (s_tuser 1), and every input transfer
// yields exactly one output transfer carrying the accepted flag, a signed
// sample and the busy flag. One transfer is taken per clock while s_tready
// is high: the element sequencer, segment counter and phase accumulator
// update in the cycle the transfer is accepted, and the sample itself goes
// through a four stage path (sequencer register, sine rom read with envelope
// gain, sine times envelope, times full scale into the output register) and
// is offered on m_tvalid once it reaches the output register. Stages fill
// bubbles independently, so input keeps being taken while a finished result
// waits for m_tready, until the path is full. Registers are written through
// the apb port and should only change while no transfer is in flight; a new
// gain applies as items enter the sine stage, other values from the next
// accepted transfer, also mid character. There is no clearing pass after reset.
module morse_cw_keyer_core #(
    parameter int unsigned SINE_TABLE_DEPTH = 1024,
    parameter int unsigned PHASE_BITS       = 24,
    parameter int unsigned SAMPLE_BITS      = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tuser,   // [0] command

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] accepted, [16:1] sample, [17] busy_res, rest zero

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [15:0] dit_samples_reg;
    logic [11:0] ramp_samples_reg;
    logic [15:0] ramp_gain_reg;
    logic [23:0] phase_step_reg;

    logic                                cfg_write;
    logic [1:0]                          cfg_index;
    logic                                in_fire;
    logic                                load2;
    logic                                v1;
    cwk_pkg::cwk_flags_t                 flags1;
    logic [$clog2(SINE_TABLE_DEPTH)-1:0] k1;
    logic [cwk_pkg::COUNT_W-1:0]         x1;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // registers sit on word boundaries, low address bits are ignored
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dit_samples_reg  <= 16'd2880;
            ramp_samples_reg <= 12'd144;
            ramp_gain_reg    <= 16'd228;
            phase_step_reg   <= 24'd209715;
        end else if (cfg_write) begin
            unique case (cfg_index)
                cwk_pkg::REG_DIT_SAMPLES:  dit_samples_reg  <= pwdata[15:0];
                cwk_pkg::REG_RAMP_SAMPLES: ramp_samples_reg <= pwdata[11:0];
                cwk_pkg::REG_RAMP_GAIN:    ramp_gain_reg    <= pwdata[15:0];
                cwk_pkg::REG_PHASE_STEP:   phase_step_reg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        unique case (cfg_index)
            cwk_pkg::REG_DIT_SAMPLES:  prdata = 32'(dit_samples_reg);
            cwk_pkg::REG_RAMP_SAMPLES: prdata = 32'(ramp_samples_reg);
            cwk_pkg::REG_RAMP_GAIN:    prdata = 32'(ramp_gain_reg);
            cwk_pkg::REG_PHASE_STEP:   prdata = 32'(phase_step_reg);
            default:                   prdata = '0;
        endcase
    end

    // first stage is free or moving on into the sine stage
    assign s_tready = !v1 || load2;
    assign in_fire  = s_tvalid && s_tready;

    // sequencer: keyer state and per sample table index and ramp position
    cwk_seq #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .PHASE_BITS      (PHASE_BITS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .command      (s_tuser),
        .character    (s_tdata),
        .load2        (load2),
        .dit_samples  (dit_samples_reg),
        .ramp_samples (ramp_samples_reg),
        .phase_step   (phase_step_reg),
        .v1           (v1),
        .flags1       (flags1),
        .k1           (k1),
        .x1           (x1)
    );

    // sample path: sine lookup, envelope and scaling into the output register
    cwk_shaper #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_shaper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .v1        (v1),
        .flags1    (flags1),
        .k1        (k1),
        .x1        (x1),
        .ramp_gain (ramp_gain_reg),
        .m_tready  (m_tready),
        .load2     (load2),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: hdl/cwk_sine_rom.sv
// cwk_sine_rom: sign-magnitude sine table built at elaboration, registered read
// no dependencies
`timescale 1ns / 1ps

module cwk_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                rd_en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] rd_addr,
    output logic [15:0]                         rd_data
);

    typedef logic [15:0] rom_t [SINE_TABLE_DEPTH];

    // bit 15 is the sign, bits 14:0 the magnitude in q0.15
    function automatic logic [15:0] sine_val(input longint unsigned k);
        longint unsigned q, quad, f, u, u2, t, m;
        q    = (k * 64'd131072) / SINE_TABLE_DEPTH;
        quad = (q >> 15) & 64'd3;
        f    = q & 64'd32767;
        u    = quad[0] ? 64'd32768 - f : f;
        u2   = (u * u) >> 15;
        t    = 64'd5026937;
        t    = 64'd85569278 - ((t * u2) >> 15);
        t    = 64'd693598673 - ((t * u2) >> 15);
        t    = 64'd1686629713 - ((t * u2) >> 15);
        m    = (t * u) >> 30;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return {quad[1], m[14:0]};
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) begin
            r[i] = sine_val(longint'(i));
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [15:0] data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_reg <= SINE_ROM[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

FILE: hdl/cwk_seq.sv
// cwk_seq: element sequencer, segment timing, phase accumulator and envelope index
// depends on cwk_pkg; holds the first pipeline register of the sample path
`timescale 1ns / 1ps

module cwk_seq #(
    parameter int unsigned SINE_TABLE_DEPTH = 1024,
    parameter int unsigned PHASE_BITS       = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_fire,
    input  logic                                command,
    input  logic [7:0]                          character,
    input  logic                                load2,
    input  logic [15:0]                         dit_samples,
    input  logic [11:0]                         ramp_samples,
    input  logic [23:0]                         phase_step,
    output logic                                v1,
    output cwk_pkg::cwk_flags_t                 flags1,
    output logic [$clog2(SINE_TABLE_DEPTH)-1:0] k1,
    output logic [cwk_pkg::COUNT_W-1:0]         x1
);

    localparam int unsigned ADDR_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int unsigned KPROD_W = PHASE_BITS + DEPTH_W;
    localparam int unsigned CW      = cwk_pkg::COUNT_W;

    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_FIRST   = 8'd33;
    localparam logic [7:0] CHAR_LAST    = 8'd95;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

    cwk_pkg::seg_kind_t kind_reg, kind_next;
    logic [6:0]         pattern_reg, pattern_next;
    logic [2:0]         count_reg, count_next;
    logic [2:0]         index_reg, index_next;
    logic [CW-1:0]      counter_reg, counter_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic               busy_reg, busy_next;

    logic                v1_reg;
    cwk_pkg::cwk_flags_t flags1_reg, flags1_next;
    logic [ADDR_W-1:0]   k1_reg;
    logic [CW-1:0]       x1_reg, x1_next;

    logic [7:0]           c_up;
    cwk_pkg::morse_code_t code;
    logic [17:0]          dit3;
    logic [CW-1:0]        dit9;
    logic [CW-1:0]        len_raw;
    logic [CW-1:0]        seg_len;
    logic [7:0]           pattern_ext;
    logic [CW-1:0]        counter_inc;
    logic [2:0]           index_inc;
    logic [CW:0]          end_sum;
    logic                 in_rise;
    logic                 in_fall;
    logic [KPROD_W-1:0]   kprod;

    assign c_up = (character >= CHAR_LOWER_A && character <= CHAR_LOWER_Z)
                  ? character - 8'd32 : character;
    assign code = cwk_pkg::morse_lookup(6'(c_up - CHAR_SPACE));

    assign dit3 = {1'b0, dit_samples, 1'b0} + 18'(dit_samples);
    assign dit9 = {1'b0, dit_samples, 3'b000} + 20'(dit_samples);
    assign pattern_ext = {1'b0, pattern_reg};

    always_comb begin
        unique case (kind_reg)
            cwk_pkg::KIND_TONE:       len_raw = pattern_ext[index_reg] ? CW'(dit3)
                                                                       : CW'(dit_samples);
            cwk_pkg::KIND_ELEM_GAP:   len_raw = CW'(dit_samples);
            cwk_pkg::KIND_LETTER_GAP: len_raw = CW'(dit3);
            default:                  len_raw = dit9;
        endcase
    end

    assign seg_len     = (len_raw == '0) ? CW'(1) : len_raw;
    assign counter_inc = counter_reg + CW'(1);
    assign index_inc   = index_reg + 3'd1;

    // ramp position: rising edge, falling edge or flat top
    assign end_sum = {1'b0, counter_reg} + (CW+1)'(ramp_samples);
    assign in_rise = {8'd0, ramp_samples} > counter_reg;
    assign in_fall = end_sum >= {1'b0, seg_len};

    assign kprod = KPROD_W'(phase_reg) * KPROD_W'(SINE_TABLE_DEPTH);

    always_comb begin
        kind_next    = kind_reg;
        pattern_next = pattern_reg;
        count_next   = count_reg;
        index_next   = index_reg;
        counter_next = counter_reg;
        phase_next   = phase_reg;
        busy_next    = busy_reg;
        flags1_next  = '0;
        x1_next      = '0;

        if (in_rise) begin
            x1_next = counter_reg;
        end else if (seg_len > counter_reg) begin
            x1_next = seg_len - counter_reg;
        end

        if (command == cwk_pkg::CMD_SUBMIT) begin
            if (!busy_reg) begin
                flags1_next.accepted = 1'b1;
                if (c_up == CHAR_SPACE) begin
                    kind_next    = cwk_pkg::KIND_WORD_GAP;
                    counter_next = '0;
                    busy_next    = 1'b1;
                end else if (c_up >= CHAR_FIRST && c_up <= CHAR_LAST
                             && code.count != 3'd0) begin
                    pattern_next = code.pattern;
                    count_next   = code.count;
                    index_next   = 3'd0;
                    kind_next    = cwk_pkg::KIND_TONE;
                    counter_next = '0;
                    phase_next   = '0;
                    busy_next    = 1'b1;
                end
            end
        end else if (kind_reg == cwk_pkg::KIND_IDLE) begin
            busy_next = 1'b0;
        end else begin
            if (kind_reg == cwk_pkg::KIND_TONE) begin
                flags1_next.is_tone  = 1'b1;
                flags1_next.env_full = (ramp_samples == '0) || !(in_rise || in_fall);
                phase_next = phase_reg + PHASE_BITS'(phase_step);
            end
            counter_next = counter_inc;
            if (counter_inc >= seg_len) begin
                counter_next = '0;
                priority case (kind_reg)
                    cwk_pkg::KIND_TONE: begin
                        kind_next = cwk_pkg::KIND_ELEM_GAP;
                    end
                    cwk_pkg::KIND_ELEM_GAP: begin
                        index_next = index_inc;
                        if (index_inc < count_reg) begin
                            kind_next  = cwk_pkg::KIND_TONE;
                            phase_next = '0;
                        end else begin
                            kind_next = cwk_pkg::KIND_LETTER_GAP;
                        end
                    end
                    default: begin
                        kind_next = cwk_pkg::KIND_IDLE;
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
        flags1_next.busy_res = busy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg    <= cwk_pkg::KIND_IDLE;
            pattern_reg <= '0;
            count_reg   <= '0;
            index_reg   <= '0;
            counter_reg <= '0;
            phase_reg   <= '0;
            busy_reg    <= 1'b0;
            v1_reg      <= 1'b0;
        end else begin
            if (in_fire) begin
                kind_reg    <= kind_next;
                pattern_reg <= pattern_next;
                count_reg   <= count_next;
                index_reg   <= index_next;
                counter_reg <= counter_next;
                phase_reg   <= phase_next;
                busy_reg    <= busy_next;
                v1_reg      <= 1'b1;
            end else if (load2) begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            flags1_reg <= flags1_next;
            k1_reg     <= kprod[PHASE_BITS +: ADDR_W];
            x1_reg     <= x1_next;
        end
    end

    assign v1     = v1_reg;
    assign flags1 = flags1_reg;
    assign k1     = k1_reg;
    assign x1     = x1_reg;

    // busy tracks exactly whether a segment is running
    a_busy_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg == (kind_reg != cwk_pkg::KIND_IDLE))
        else $error("busy flag out of step with segment kind");

    // a tone always belongs to an element that exists
    a_tone_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg == cwk_pkg::KIND_TONE) |-> (index_reg < count_reg))
        else $error("tone segment past last element");

    // a submit while busy is refused
    a_busy_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && command == cwk_pkg::CMD_SUBMIT && busy_reg)
        |=> (!flags1_reg.accepted && flags1_reg.busy_res))
        else $error("submit taken while busy");

endmodule

FILE: hdl/cwk_shaper.sv
// cwk_shaper: sine lookup, envelope gain and amplitude scaling with output register
// depends on cwk_pkg and cwk_sine_rom
`timescale 1ns / 1ps

module cwk_shaper #(
    parameter int unsigned SINE_TABLE_DEPTH = 1024,
    parameter int unsigned SAMPLE_BITS      = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                v1,
    input  cwk_pkg::cwk_flags_t                 flags1,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] k1,
    input  logic [cwk_pkg::COUNT_W-1:0]         x1,
    input  logic [15:0]                         ramp_gain,
    input  logic                                m_tready,
    output logic                                load2,
    output logic                                m_tvalid,
    output logic [23:0]                         m_tdata
);

    localparam int unsigned ENV_W  = cwk_pkg::ENV_W;
    localparam int unsigned MAG_W  = cwk_pkg::MAG_W;
    localparam int unsigned AMP_W  = SAMPLE_BITS - 1;
    localparam int unsigned GP_W   = cwk_pkg::COUNT_W + 16;
    localparam int unsigned P3_W   = MAG_W + ENV_W;
    localparam int unsigned P4_W   = P3_W + AMP_W;
    localparam logic [AMP_W-1:0] AMP_MAX = {AMP_W{1'b1}};

    logic load3, load4;
    logic v2_reg, v3_reg, v4_reg;

    cwk_pkg::cwk_flags_t flags2_reg, flags3_reg;
    logic [ENV_W-1:0]    env2_reg;
    logic [P3_W-1:0]     p3_reg;
    logic                neg3_reg;

    logic                accepted4_reg, busy4_reg;
    logic [15:0]         sample4_reg;

    logic [15:0]         sine2;
    logic [GP_W-1:0]     gprod;
    logic [GP_W-2:0]     ghalf;
    logic [ENV_W-1:0]    env_next;
    logic [P4_W-1:0]     p4;
    logic [31:0]         v_ext;
    logic [15:0]         sample_next;

    // each stage loads when it is empty or its content moves on
    assign load4 = !v4_reg || m_tready;
    assign load3 = !v3_reg || load4;
    assign load2 = !v2_reg || load3;

    cwk_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (load2),
        .rd_addr (k1),
        .rd_data (sine2)
    );

    assign gprod = GP_W'(x1) * GP_W'(ramp_gain);
    assign ghalf = gprod[GP_W-1:1];

    always_comb begin
        if (flags1.env_full || ghalf > (GP_W-1)'(cwk_pkg::ENV_ONE)) begin
            env_next = cwk_pkg::ENV_ONE;
        end else begin
            env_next = ghalf[ENV_W-1:0];
        end
    end

    assign p4    = P4_W'(p3_reg) * P4_W'(AMP_MAX);
    assign v_ext = 32'(p4[30 +: AMP_W]);

    always_comb begin
        if (!flags3_reg.is_tone) begin
            sample_next = '0;
        end else if (neg3_reg) begin
            sample_next = 16'(32'd0 - v_ext);
        end else begin
            sample_next = v_ext[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (load2) v2_reg <= v1;
            if (load3) v3_reg <= v2_reg;
            if (load4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            flags2_reg <= flags1;
            env2_reg   <= env_next;
        end
        if (load3) begin
            flags3_reg <= flags2_reg;
            p3_reg     <= P3_W'(sine2[MAG_W-1:0]) * P3_W'(env2_reg);
            neg3_reg   <= sine2[15];
        end
        if (load4) begin
            accepted4_reg <= flags3_reg.accepted;
            busy4_reg     <= flags3_reg.busy_res;
            sample4_reg   <= sample_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {6'd0, busy4_reg, sample4_reg, accepted4_reg};

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for the morse cw keyer core
// drives character submits and sample ticks, predicts every result transfer
// depends on cwk_pkg and morse_cw_keyer_core
`timescale 1ns / 1ps

module tb_top;

    // pipeline depth of the core plus a little margin, used before register writes
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic        accepted;
        logic [15:0] sample;
        logic        busy;
    } keyer_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] character
    logic        s_tuser  = 1'b0;   // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [0] accepted, [16:1] sample, [17] busy_res
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    morse_cw_keyer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // generous fixed bound on the whole run
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // keyer model state, mirrors the core from reset onwards
    // ------------------------------------------------------------------
    logic [15:0] cfg_dit   = 16'd2880;
    logic [11:0] cfg_ramp  = 12'd144;
    logic [15:0] cfg_gain  = 16'd228;
    logic [23:0] cfg_step  = 24'd209715;

    logic [7:0]  pat_q   = '0;   // bit i set: element i is a dah
    logic [2:0]  cnt_q   = '0;
    logic [2:0]  idx_q   = '0;
    cwk_pkg::seg_kind_t kind_q = cwk_pkg::KIND_IDLE;
    logic [19:0] ctr_q   = '0;   // samples already sent in the segment
    logic [23:0] phase_q = '0;
    logic        busy_q  = 1'b0;

    int sine_q15 [1024];         // q1.15 sine, filled at time zero

    // morse text for ascii 32..95, empty where the character has no code
    string morse_of [64] = '{
        "", "-.-.--", ".-..-.", "", "...-..-", "", ".-...", ".----.",
        "-.--.", "-.--.-", "", ".-.-.", "--..--", "-....-", ".-.-.-", "-..-.",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.", "---...", "-.-.-.", "", "-...-", "", "..--..",
        ".--.-.", ".-", "-...", "-.-.", "-..", ".", "..-.", "--.",
        "....", "..", ".---", "-.-", ".-..", "--", "-.", "---",
        ".--.", "--.-", ".-.", "...", "-", "..-", "...-", ".--",
        "-..-", "-.--", "--..", "", "", "", "", "..--.-"
    };

    keyer_result_t pending_results [$];
    int error_count = 0;
    bit gaps_on     = 1'b1;
    int rx_hold     = 0;

    // advance the keyer model by one accepted transfer
    function automatic keyer_result_t keyer_predict(input logic cmd, input logic [7:0] ch);
        keyer_result_t r;
        int unsigned c, n, len;
        string code;
        logic [7:0] pat;
        longint unsigned mag, env, x, v;
        int s;
        bit ramped;
        r = '{accepted: 1'b0, sample: 16'h0000, busy: 1'b0};
        if (cmd == cwk_pkg::CMD_SUBMIT) begin
            // a submit while busy is dropped with accepted low
            if (!busy_q) begin
                r.accepted = 1'b1;
                c = ch;
                if (c >= 97 && c <= 122) c = c - 32;
                if (c == 32) begin
                    kind_q = cwk_pkg::KIND_WORD_GAP;
                    ctr_q  = '0;
                    busy_q = 1'b1;
                end else if (c >= 33 && c <= 95) begin
                    code = morse_of[c - 32];
                    n = 0;
                    pat = '0;
                    while (n < 7 && n < code.len()) begin
                        if (code[n] == "-") pat[n] = 1'b1;
                        n++;
                    end
                    // characters with no code are taken but send nothing
                    if (n != 0) begin
                        pat_q   = pat;
                        cnt_q   = n[2:0];
                        idx_q   = '0;
                        kind_q  = cwk_pkg::KIND_TONE;
                        ctr_q   = '0;
                        phase_q = '0;
                        busy_q  = 1'b1;
                    end
                end
            end
            r.busy = busy_q;
            return r;
        end

        // tick while idle gives silence
        if (kind_q == cwk_pkg::KIND_IDLE) begin
            busy_q = 1'b0;
            return r;
        end

        case (kind_q)
            cwk_pkg::KIND_TONE:       len = pat_q[idx_q] ? 3 * cfg_dit : cfg_dit;
            cwk_pkg::KIND_ELEM_GAP:   len = cfg_dit;
            cwk_pkg::KIND_LETTER_GAP: len = 3 * cfg_dit;
            default:                  len = 9 * cfg_dit;
        endcase
        // a zero dit still lasts one sample
        if (len == 0) len = 1;

        if (kind_q == cwk_pkg::KIND_TONE) begin
            s = sine_q15[phase_q[23:14]];
            if (s < 0) mag = -s;
            else mag = s;
            env = 64'd32768;
            ramped = 1'b0;
            x = 0;
            if (cfg_ramp != 0) begin
                if (ctr_q < cfg_ramp) begin
                    x = ctr_q;
                    ramped = 1'b1;
                end else if (ctr_q + cfg_ramp >= len) begin
                    x = (len > ctr_q) ? len - ctr_q : 0;
                    ramped = 1'b1;
                end
            end
            if (ramped) begin
                env = (x * cfg_gain) >> 1;
                if (env > 64'd32768) env = 64'd32768;
            end
            v = (mag * env * 64'd32767) >> 30;
            r.sample = v[15:0];
            if (s < 0) r.sample = -r.sample;
            phase_q = phase_q + cfg_step;
        end

        ctr_q = ctr_q + 20'd1;
        // a shortened segment whose counter is already past its length ends here
        if (ctr_q >= len) begin
            ctr_q = '0;
            if (kind_q == cwk_pkg::KIND_TONE) begin
                kind_q = cwk_pkg::KIND_ELEM_GAP;
            end else if (kind_q == cwk_pkg::KIND_ELEM_GAP) begin
                idx_q = idx_q + 3'd1;
                if (idx_q < cnt_q) begin
                    kind_q  = cwk_pkg::KIND_TONE;
                    phase_q = '0;
                end else begin
                    kind_q = cwk_pkg::KIND_LETTER_GAP;
                end
            end else begin
                kind_q = cwk_pkg::KIND_IDLE;
                busy_q = 1'b0;
            end
        end
        r.busy = busy_q;
        return r;
    endfunction

    // mostly short gaps, a few long ones, none while gaps are switched off
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ------------------------------------------------------------------
    // result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : rx_pace
        int g;
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            g = pick_gap();
            m_tready <= (g == 0);
            rx_hold = g;
        end
    end

    always @(posedge aclk) begin : result_check
        keyer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result transfer with nothing expected, expected none, got %h",
                         $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.accepted) begin
                    error_count++;
                    $display("%0t: accepted mismatch, expected %0b, got %0b",
                             $time, want.accepted, m_tdata[0]);
                end
                if (m_tdata[16:1] !== want.sample) begin
                    error_count++;
                    $display("%0t: sample mismatch, expected %0d, got %0d",
                             $time, $signed(want.sample), $signed(m_tdata[16:1]));
                end
                if (m_tdata[17] !== want.busy) begin
                    error_count++;
                    $display("%0t: busy mismatch, expected %0b, got %0b",
                             $time, want.busy, m_tdata[17]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------

    // one input transfer; the model steps at the edge where it is taken
    task automatic send_item(input logic cmd, input logic [7:0] ch);
        int gap;
        keyer_result_t want;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = keyer_predict(cmd, ch);
        pending_results.insert(pending_results.size(), want);
    endtask

    // stop sending and let every outstanding result come back
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic tick_until_idle();
        while (busy_q) send_item(cwk_pkg::CMD_TICK, 8'($urandom));
    endtask

    // apb read, compared with the value the register should hold
    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want) begin
            error_count++;
            $display("%0t: register %0d readback mismatch, expected %h, got %h",
                     $time, idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // deselect and idle before the next access
        @(posedge aclk);
    endtask

    // apb write with the core drained first, then read back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] held;
        quiesce();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            cwk_pkg::REG_DIT_SAMPLES: begin
                cfg_dit = value[15:0];
                held = {16'h0, cfg_dit};
            end
            cwk_pkg::REG_RAMP_SAMPLES: begin
                cfg_ramp = value[11:0];
                held = {20'h0, cfg_ramp};
            end
            cwk_pkg::REG_RAMP_GAIN: begin
                cfg_gain = value[15:0];
                held = {16'h0, cfg_gain};
            end
            default: begin
                cfg_step = value[23:0];
                held = {8'h0, cfg_step};
            end
        endcase
        check_reg(idx, held);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_register_reset();
        check_reg(cwk_pkg::REG_DIT_SAMPLES, 32'd2880);
        check_reg(cwk_pkg::REG_RAMP_SAMPLES, 32'd144);
        check_reg(cwk_pkg::REG_RAMP_GAIN, 32'd228);
        check_reg(cwk_pkg::REG_PHASE_STEP, 32'd209715);
    endtask

    // ticks with nothing queued give silence and not busy
    task automatic test_idle_ticks();
        repeat (3) send_item(cwk_pkg::CMD_TICK, 8'hFF);
    endtask

    // reset settings: lower case folding, the start of the rise ramp, a submit
    // while busy, the dit shortened under a running tone, then a word space
    task automatic test_default_tone();
        send_item(cwk_pkg::CMD_SUBMIT, "e");
        repeat (20) send_item(cwk_pkg::CMD_TICK, 8'h00);
        send_item(cwk_pkg::CMD_SUBMIT, "T");
        write_reg(cwk_pkg::REG_DIT_SAMPLES, 32'd1);
        tick_until_idle();
        send_item(cwk_pkg::CMD_SUBMIT, " ");
        tick_until_idle();
    endtask

    // every register at its top value, then cut short with no ramp and zero gain
    task automatic test_extreme_settings();
        write_reg(cwk_pkg::REG_DIT_SAMPLES, 32'd65535);
        write_reg(cwk_pkg::REG_RAMP_SAMPLES, 32'd4095);
        write_reg(cwk_pkg::REG_RAMP_GAIN, 32'd65535);
        write_reg(cwk_pkg::REG_PHASE_STEP, 32'hFF_FFFF);
        send_item(cwk_pkg::CMD_SUBMIT, "0");
        repeat (12) send_item(cwk_pkg::CMD_TICK, 8'h00);
        write_reg(cwk_pkg::REG_DIT_SAMPLES, 32'd1);
        write_reg(cwk_pkg::REG_RAMP_SAMPLES, 32'd0);
        write_reg(cwk_pkg::REG_RAMP_GAIN, 32'd0);
        tick_until_idle();
    endtask

    // zero dit: every segment lasts a single sample
    task automatic test_zero_dit();
        write_reg(cwk_pkg::REG_DIT_SAMPLES, 32'd0);
        write_reg(cwk_pkg::REG_RAMP_SAMPLES, 32'd1);
        write_reg(cwk_pkg::REG_RAMP_GAIN, 32'd32768);
        write_reg(cwk_pkg::REG_PHASE_STEP, 32'd0);
        send_item(cwk_pkg::CMD_SUBMIT, "$");
        tick_until_idle();
        send_item(cwk_pkg::CMD_SUBMIT, " ");
        tick_until_idle();
    endtask

    // characters outside the table are taken and leave the keyer idle
    task automatic test_unknown_chars();
        logic [7:0] odd [12] = '{8'h00, 8'h1F, "#", "%", "<", ">", "[", "^",
                                 8'h60, "{", 8'h7F, 8'hFF};
        write_reg(cwk_pkg::REG_DIT_SAMPLES, 32'd1);
        foreach (odd[i]) send_item(cwk_pkg::CMD_SUBMIT, odd[i]);
        send_item(cwk_pkg::CMD_TICK, 8'h00);
    endtask

    // whole characters with random text under several settings; a few
    // phases without gaps, the odd drain and submits that land while busy
    task automatic test_random_traffic();
        int done, phase, r, quota;
        int unsigned dit, ramp, gain, step;
        logic cmd;
        logic [7:0] ch;
        logic was_busy;
        done = 0;
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 1) dit = 1;
            else if ($urandom_range(0, 9) == 0) dit = $urandom_range(6, 12);
            else dit = $urandom_range(1, 5);
            if (phase == 2) ramp = 0;
            else if (phase == 3) ramp = 4095;
            else ramp = $urandom_range(1, 3 * dit);
            if (phase == 4) gain = 65535;
            else if (ramp == 0 || $urandom_range(0, 3) == 0) gain = $urandom_range(0, 65535);
            else gain = (65536 / ramp > 65535) ? 65535 : 65536 / ramp;
            if (phase == 5) step = 24'hFF_FFFF;
            else if (phase == 6) step = 0;
            else step = $urandom_range(0, 24'hFF_FFFF);
            // a character may still be running across these writes
            write_reg(cwk_pkg::REG_DIT_SAMPLES, dit);
            write_reg(cwk_pkg::REG_RAMP_SAMPLES, ramp);
            write_reg(cwk_pkg::REG_RAMP_GAIN, gain);
            write_reg(cwk_pkg::REG_PHASE_STEP, step);
            gaps_on = (phase % 4) != 3;

            quota = done + 170;
            while (done < quota) begin
                r = $urandom_range(0, 99);
                if (r < 2) quiesce();
                was_busy = busy_q;
                r = $urandom_range(0, 99);
                cmd = cwk_pkg::CMD_TICK;
                ch  = 8'($urandom);
                if ((was_busy && r >= 88) || (!was_busy && r < 82)) begin
                    cmd = cwk_pkg::CMD_SUBMIT;
                    r = $urandom_range(0, 99);
                    if (r < 55) ch = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "a" : "A");
                    else if (r < 75) ch = 8'($urandom_range(32, 95));
                    else if (r < 85) ch = " ";
                end
                send_item(cmd, ch);
                if (cmd == cwk_pkg::CMD_TICK || !was_busy) done++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin : stimulus
        int k;
        longint unsigned q, quad, f, u, u2, t, m;
        // q1.15 sine by an odd polynomial on each quarter wave
        for (k = 0; k < 1024; k++) begin
            q    = (longint'(k) * 131072) / 1024;
            quad = (q >> 15) & 3;
            f    = q & 32767;
            u    = quad[0] ? 32768 - f : f;
            u2   = (u * u) >> 15;
            t    = 5026937;
            t    = 85569278 - ((t * u2) >> 15);
            t    = 693598673 - ((t * u2) >> 15);
            t    = 1686629713 - ((t * u2) >> 15);
            m    = (t * u) >> 30;
            if (m > 32767) m = 32767;
            sine_q15[k] = (quad >= 2) ? -int'(m) : int'(m);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_reset();
        test_idle_ticks();
        test_default_tone();
        test_extreme_settings();
        test_zero_dit();
        test_unknown_chars();
        test_random_traffic();

        quiesce();
        repeat (16) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
